### src/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

### src/ffha_pkg.sv
// Shared types and codes for the first-fit hole allocator.
`default_nettype none
package ffha_pkg;
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_OOM  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;
   localparam int BASE_W = 16;
   localparam int SIZE_W = 17;
   localparam int HOLE_W = 33;
   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic [SIZE_W-1:0] size;
   } hole_type;
endpackage
`default_nettype wire

### src/first_fit_hole_allocator.sv
// An allocate scans the holes in order and takes the first that fits; an exact fit drops the
// entry and moves later entries down, and a miss answers OOM. A free scans to its place, then
// merges with the hole below, above or both, or inserts by moving later entries up.
// An ignored free or an allocate with no holes answers without reading the table. Only one
// request at a time is taken on the single table RAM; a waiting result holds the next one.
// Reset: synchronous; the S_INIT step then writes one hole spanning all of memory.
`default_nettype none
module first_fit_hole_allocator #(
   parameter int MEM_WORDS = 65536,
   parameter int HOLE_SLOTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [16:0] req_req_size,
   input  wire logic [15:0] req_free_base,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_alloc_base,
   output logic [1:0]       rsp_status,
   output logic [6:0]       rsp_holes_in_use
);
   import ffha_pkg::*;
`include "assert_macros.svh"
   localparam int IW = $clog2(HOLE_SLOTS);
   localparam int CW = IW + 1;
   localparam logic [SIZE_W:0] MEMW = (SIZE_W+1)'(MEM_WORDS);

   localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_CHK = 4'd2, S_DEC = 4'd3,
      S_WR = 4'd4, S_SHR = 4'd5, S_SHW = 4'd6, S_DONE = 4'd7, S_RDB = 4'd8,
      S_CHB = 4'd9, S_INIT = 4'd10;
   logic [3:0] state_ff, state_in;

   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in, pos_ff, pos_in;
   logic kind_ff, kind_in;
   logic [SIZE_W-1:0] sz_ff, sz_in;
   logic [BASE_W-1:0] fb_ff, fb_in;
   hole_type prev_ff, prev_in, cur_ff, cur_in;
   logic [1:0] mode_ff, mode_in; // 0 insert, 1 below, 2 above, 3 both
   logic [BASE_W-1:0] ob_ff, ob_in;
   logic [1:0] os_ff, os_in;
   logic ov_ff, ov_in;
   // The result is copied here so that the next request can run while it waits.
   logic [BASE_W-1:0] rb_ff;
   logic [1:0] rs_ff;
   logic [6:0] rh_ff;

   logic wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   hole_type wr_data, rd_data;

   ffha_ram #(.WIDTH(HOLE_W), .DEPTH(HOLE_SLOTS)) u_tab (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   logic [SIZE_W:0] prev_end, fb_end;
   assign prev_end = {1'b0, prev_ff.base} + {1'b0, prev_ff.size};
   assign fb_end   = {1'b0, fb_ff} + {1'b0, sz_ff};

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; idx_in = idx_ff; pos_in = pos_ff;
      kind_in = kind_ff; sz_in = sz_ff; fb_in = fb_ff; prev_in = prev_ff;
      cur_in = cur_ff; mode_in = mode_ff; ob_in = ob_ff; os_in = os_ff;
      ov_in = ov_ff;
      wr_en = 1'b0; wr_addr = idx_ff[IW-1:0]; wr_data = cur_ff;
      rd_addr = idx_ff[IW-1:0];
      case (state_ff)
         S_INIT: begin
            wr_en = 1'b1; wr_addr = '0;
            wr_data.base = '0; wr_data.size = SIZE_W'(MEM_WORDS);
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind; sz_in = req_req_size; fb_in = req_free_base;
               idx_in = '0; pos_in = cnt_ff; ob_in = '0; os_in = STATUS_OK;
               if (req_kind == KIND_ALLOC) begin
                  os_in = STATUS_OOM;
                  state_in = (cnt_ff == '0) ? S_DONE : S_RD;
               end else if (req_req_size == '0 || {1'b0, req_free_base} >=
                            MEMW[SIZE_W:0]) begin
                  state_in = S_DONE;
               end else begin
                  if ({1'b0, req_free_base} + {1'b0, req_req_size} > MEMW)
                     sz_in = SIZE_W'(MEMW - {1'b0, req_free_base});
                  state_in = (cnt_ff == '0) ? S_CHB : S_RD;
               end
            end
         end
         S_RD: state_in = S_CHK; // read issued at idx
         S_CHK: begin
            cur_in = rd_data;
            if (kind_ff == KIND_ALLOC) begin
               if (rd_data.size >= sz_ff) begin
                  ob_in = rd_data.base; os_in = STATUS_OK;
                  cur_in.base = rd_data.base + sz_ff[BASE_W-1:0];
                  cur_in.size = rd_data.size - sz_ff;
                  if (rd_data.size == sz_ff) begin
                     pos_in = idx_ff; state_in = S_DEC;
                  end else state_in = S_WR;
               end else if (idx_ff + 1'b1 == cnt_ff) state_in = S_DONE;
               else begin
                  idx_in = idx_ff + 1'b1; state_in = S_RD;
               end
            end else begin
               if (rd_data.base > fb_ff) begin
                  pos_in = idx_ff; state_in = S_CHB;
               end else begin
                  prev_in = rd_data;
                  if (idx_ff + 1'b1 == cnt_ff) begin
                     pos_in = cnt_ff; state_in = S_CHB;
                  end else begin
                     idx_in = idx_ff + 1'b1; state_in = S_RD;
                  end
               end
            end
         end
         S_CHB: begin
            // pos holds the insertion point; cur holds entry pos if any.
            if (pos_ff != '0 && prev_end == {1'b0, fb_ff}) mode_in[0] = 1'b1;
            else mode_in[0] = 1'b0;
            if (pos_ff < cnt_ff && fb_end == {1'b0, cur_ff.base}) mode_in[1] = 1'b1;
            else mode_in[1] = 1'b0;
            state_in = S_RDB;
         end
         S_RDB: begin
            case (mode_ff)
               2'd3: begin
                  wr_en = 1'b1; wr_addr = IW'(pos_ff - 1'b1);
                  wr_data.base = prev_ff.base;
                  wr_data.size = prev_ff.size + sz_ff + cur_ff.size;
                  state_in = S_DEC;
               end
               2'd1: begin
                  wr_en = 1'b1; wr_addr = IW'(pos_ff - 1'b1);
                  wr_data.base = prev_ff.base; wr_data.size = prev_ff.size + sz_ff;
                  state_in = S_DONE;
               end
               2'd2: begin
                  wr_en = 1'b1; wr_addr = pos_ff[IW-1:0];
                  wr_data.base = fb_ff; wr_data.size = cur_ff.size + sz_ff;
                  state_in = S_DONE;
               end
               default: begin
                  if (cnt_ff >= CW'(HOLE_SLOTS)) begin
                     os_in = STATUS_FULL; state_in = S_DONE;
                  end else begin
                     idx_in = cnt_ff; state_in = S_SHR;
                  end
               end
            endcase
         end
         S_WR: begin
            wr_en = 1'b1; state_in = S_DONE;
         end
         S_DEC: begin
            // Drop entry pos by moving later entries down one place.
            if (pos_ff + 1'b1 >= cnt_ff) begin
               cnt_in = cnt_ff - 1'b1; state_in = S_DONE;
            end else begin
               rd_addr = IW'(pos_ff + 1'b1); idx_in = pos_ff; mode_in = 2'd0;
               pos_in = pos_ff + 1'b1; state_in = S_SHW;
               kind_in = KIND_ALLOC; // marks a downward move
            end
         end
         S_SHR: begin
            // Insert: move entry idx-1 up to idx, walking down to pos.
            if (idx_ff == pos_ff) begin
               wr_en = 1'b1; wr_data.base = fb_ff; wr_data.size = sz_ff;
               cnt_in = cnt_ff + 1'b1; state_in = S_DONE;
            end else begin
               rd_addr = IW'(idx_ff - 1'b1); kind_in = KIND_FREE; state_in = S_SHW;
            end
         end
         S_SHW: begin
            wr_en = 1'b1; wr_data = rd_data;
            if (kind_ff == KIND_FREE) begin
               idx_in = idx_ff - 1'b1; state_in = S_SHR;
            end else begin
               idx_in = idx_ff + 1'b1; state_in = S_DEC;
            end
         end
         S_DONE: begin
            if (!ov_ff) begin
               ov_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; cnt_ff <= CW'(1); ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in;
         ov_ff <= (rsp_valid && rsp_ready) ? 1'b0 : ov_in;
      end
      idx_ff <= idx_in; pos_ff <= pos_in; kind_ff <= kind_in; sz_ff <= sz_in;
      fb_ff <= fb_in; prev_ff <= prev_in; cur_ff <= cur_in; mode_ff <= mode_in;
      ob_ff <= ob_in; os_ff <= os_in;
      if (state_ff == S_DONE && !ov_ff) begin
         rb_ff <= ob_ff; rs_ff <= os_ff; rh_ff <= 7'(cnt_ff);
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_alloc_base = rb_ff;
   assign rsp_status = rs_ff;
   assign rsp_holes_in_use = rh_ff;

   `ASSERT_IMPLIES(a_cnt_max, clock, reset, 1'b1, cnt_ff <= CW'(HOLE_SLOTS))
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rb_ff) && $stable(rs_ff) && $stable(rh_ff))
   `ASSERT_NEXT(a_done, clock, reset, state_ff == S_DONE && !rsp_valid, rsp_valid)
endmodule
`default_nettype wire

### src/ffha_ram.sv
// Generic RAM with one write port and one registered read port.
`default_nettype none
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
